// ===== design/mast_pkg.sv =====
// ----------------------------------------------------------------------------
// mast_pkg: shared types and constants for the address statistics table
// Holds the entry record layout, the request codes and the default sizes.
// ----------------------------------------------------------------------------
package mast_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_LANE_BITS   = 2;

    localparam logic [11:0] CHECKSUM_BYTES = 12'd4;

    // request function codes
    localparam logic [1:0] FUNC_COUNT = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // frame type codes
    localparam logic [1:0] PTYPE_MGMT = 2'd0;
    localparam logic [1:0] PTYPE_DATA = 2'd2;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] mgmt_tx;
        logic [31:0] mgmt_rx;
        logic [31:0] data_tx;
        logic [31:0] data_rx;
        logic [63:0] tx_bytes;
        logic [63:0] rx_bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/mast_ram.sv =====
// ----------------------------------------------------------------------------
// mast_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/mast_lane.sv =====
// ----------------------------------------------------------------------------
// mast_lane: one bank of the table with its address comparator
// Holds every NUM_LANES-th entry and flags a match against the search key.
// ----------------------------------------------------------------------------
module mast_lane #(
    parameter int BANK_DEPTH = 16,
    parameter int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [RW-1:0]   rd_row,
    input  logic            rd_live,
    input  logic            wr_en,
    input  logic [RW-1:0]   wr_row,
    input  mast_pkg::entry_t wr_rec,
    input  logic [47:0]     key,
    output logic            hit,
    output mast_pkg::entry_t rd_rec
);

    logic live_reg;
    logic [mast_pkg::ENTRY_W-1:0] rdata;

    mast_ram #(
        .WIDTH (mast_pkg::ENTRY_W),
        .DEPTH (BANK_DEPTH),
        .AW    (RW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_row),
        .wdata (wr_rec),
        .raddr (rd_row),
        .rdata (rdata)
    );

    // track whether the row being read back is inside the filled region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= rd_live;
        end
    end

    assign rd_rec = mast_pkg::entry_t'(rdata);
    assign hit    = live_reg && (rd_rec.mac == key);

endmodule

// ===== design/mast_merge.sv =====
// ----------------------------------------------------------------------------
// mast_merge: combine lane matches
// Pick the lowest lane that reports a match and encode its number.
// ----------------------------------------------------------------------------
module mast_merge #(
    parameter int NUM_LANES = 4,
    parameter int LANE_W    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
    input  logic [NUM_LANES-1:0] hits,
    output logic                 found,
    output logic [LANE_W-1:0]    lane
);

    always_comb
    begin
        found = 1'b0;
        lane  = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--)
        begin
            if (hits[l])
            begin
                found = 1'b1;
                lane  = LANE_W'(l);
            end
        end
    end

endmodule

// ===== design/mac_address_stats_table.sv =====
// ----------------------------------------------------------------------------
// mac_address_stats_table: per-address frame statistics table
// Looks up or inserts transmitter and receiver addresses and keeps counters.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  request  | in_valid/in_ready, func .. entry_index    | in
//  result   | out_valid/out_ready, tx_stored .. used_.. | out
//  config   | cfg_valid/cfg_ready, cfg_data             | in
//
//  A count request scans the filled rows twice (transmitter, then receiver),
//  NUM_LANES entries per row, through an issue and a compare state per row,
//  then writes the matched or newly inserted entry back, if there is one.
//  A read passes through a wait and a take state; clear and others go
//  straight to the done state. Both splits come from the registered RAM read.
//  Reset empties the table (fill count to zero) and clears record_enable.
//  A waiting result holds the block in its done state until out_ready.
//
module mac_address_stats_table #(
    parameter int TABLE_DEPTH = mast_pkg::DEF_TABLE_DEPTH,
    parameter int LANE_BITS   = mast_pkg::DEF_LANE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [47:0] tx_mac,
    input  logic [47:0] rx_mac,
    input  logic [1:0]  packet_type,
    input  logic [11:0] frame_length,
    input  logic [5:0]  entry_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_stored,
    output logic        rx_stored,
    output logic        entry_used,
    output logic [47:0] entry_mac,
    output logic [31:0] mgmt_tx_count,
    output logic [31:0] mgmt_rx_count,
    output logic [31:0] data_tx_count,
    output logic [31:0] data_rx_count,
    output logic [63:0] data_tx_bytes,
    output logic [63:0] data_rx_bytes,
    output logic [6:0]  used_entries
);

    localparam int NUM_LANES  = 1 << LANE_BITS;
    localparam int LANE_W     = LANE_BITS;
    localparam int BANK_DEPTH = (TABLE_DEPTH + NUM_LANES - 1) / NUM_LANES;
    localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int RCW        = $clog2(BANK_DEPTH + 1);
    localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_RDTAKE = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic              enable_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [RCW-1:0]    row_reg, row_next;
    logic              side_reg, side_next;        // 0 transmitter, 1 receiver
    logic [47:0]       key_reg, key_next;
    logic [47:0]       rx_key_reg;
    logic [1:0]        ptype_reg;
    logic [11:0]       flen_reg;
    logic [LANE_W-1:0] lane_sel_reg, lane_sel_next;
    logic [RW-1:0]     tgt_row_reg, tgt_row_next;
    mast_pkg::entry_t  rec_reg, rec_next;
    logic              tx_st_reg, tx_st_next;
    logic              rx_st_reg, rx_st_next;
    logic              used_reg, used_next;

    logic              out_valid_reg;
    logic              o_tx_reg, o_rx_reg, o_used_reg;
    mast_pkg::entry_t  o_rec_reg;
    logic [6:0]        o_fill_reg;

    logic [NUM_LANES-1:0] hits;
    logic [NUM_LANES-1:0] lane_live;
    mast_pkg::entry_t     lane_rec [NUM_LANES];
    logic                 found;
    logic [LANE_W-1:0]    found_lane;
    logic                 wr_en;
    mast_pkg::entry_t     wr_rec;
    logic [31:0]          base32;
    logic [31:0]          fill32;
    logic [63:0]          payload;

    assign fill32 = 32'(fill_reg);
    assign base32 = 32'(row_reg) << LANE_BITS;

    // payload bytes of a data frame: checksum removed, floored at zero
    assign payload = (flen_reg >= mast_pkg::CHECKSUM_BYTES) ?
                     64'(flen_reg - mast_pkg::CHECKSUM_BYTES) : 64'd0;

    // ---- lanes: one bank each, searched side by side
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            lane_live[l] = (state_reg == S_ISSUE) && ((base32 + 32'(l)) < fill32);
        end
    end

    // modified record for the write-back: bump the side's counters (management and data frames only)
    always_comb
    begin
        wr_rec = rec_reg;
        if (ptype_reg == mast_pkg::PTYPE_MGMT)
        begin
            if (side_reg)
            begin
                wr_rec.mgmt_rx = rec_reg.mgmt_rx + 32'd1;
            end
            else
            begin
                wr_rec.mgmt_tx = rec_reg.mgmt_tx + 32'd1;
            end
        end
        else if (ptype_reg == mast_pkg::PTYPE_DATA)
        begin
            if (side_reg)
            begin
                wr_rec.data_rx  = rec_reg.data_rx + 32'd1;
                wr_rec.rx_bytes = rec_reg.rx_bytes + payload;
            end
            else
            begin
                wr_rec.data_tx  = rec_reg.data_tx + 32'd1;
                wr_rec.tx_bytes = rec_reg.tx_bytes + payload;
            end
        end
    end

    assign wr_en = (state_reg == S_WRITE);

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        mast_lane #(
            .BANK_DEPTH (BANK_DEPTH),
            .RW         (RW)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .rd_row  (row_reg[RW-1:0]),
            .rd_live (lane_live[g]),
            .wr_en   (wr_en && (lane_sel_reg == LANE_W'(g))),
            .wr_row  (tgt_row_reg),
            .wr_rec  (wr_rec),
            .key     (key_reg),
            .hit     (hits[g]),
            .rd_rec  (lane_rec[g])
        );
    end

    mast_merge #(
        .NUM_LANES (NUM_LANES),
        .LANE_W    (LANE_W)
    ) u_merge (
        .hits  (hits),
        .found (found),
        .lane  (found_lane)
    );

    // ---- sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        row_next      = row_reg;
        side_next     = side_reg;
        key_next      = key_reg;
        lane_sel_next = lane_sel_reg;
        tgt_row_next  = tgt_row_reg;
        rec_next      = rec_reg;
        tx_st_next    = tx_st_reg;
        rx_st_next    = rx_st_reg;
        used_next     = used_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tx_st_next = 1'b0;
                    rx_st_next = 1'b0;
                    used_next  = 1'b0;
                    row_next   = '0;
                    side_next  = 1'b0;
                    key_next   = tx_mac;
                    state_next = S_DONE;
                    if (func == mast_pkg::FUNC_COUNT && enable_reg)
                    begin
                        state_next = S_ISSUE;
                    end
                    else if (func == mast_pkg::FUNC_READ)
                    begin
                        row_next      = RCW'(entry_index >> LANE_BITS);
                        lane_sel_next = LANE_W'(entry_index);
                        used_next     = (32'(entry_index) < fill32) &&
                                        (32'(entry_index) < TABLE_DEPTH);
                        state_next    = S_RDWAIT;
                    end
                    else if (func == mast_pkg::FUNC_CLEAR)
                    begin
                        fill_next = '0;
                    end
                end
            end
            S_ISSUE:
            begin
                if (base32 >= fill32)
                begin
                    // not in the table: take the first free entry if any
                    if (fill32 < TABLE_DEPTH)
                    begin
                        rec_next      = '0;
                        rec_next.mac  = key_reg;
                        lane_sel_next = fill32[LANE_W-1:0];
                        tgt_row_next  = RW'(fill32 >> LANE_BITS);
                        fill_next     = fill_reg + FILL_W'(1);
                        state_next    = S_WRITE;
                    end
                    else if (!side_reg)
                    begin
                        side_next  = 1'b1;
                        key_next   = rx_key_reg;
                        row_next   = '0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (found)
                begin
                    rec_next      = lane_rec[found_lane];
                    lane_sel_next = found_lane;
                    tgt_row_next  = row_reg[RW-1:0];
                    state_next    = S_WRITE;
                end
                else
                begin
                    row_next   = row_reg + RCW'(1);
                    state_next = S_ISSUE;
                end
            end
            S_WRITE:
            begin
                if (!side_reg)
                begin
                    tx_st_next = 1'b1;
                    side_next  = 1'b1;
                    key_next   = rx_key_reg;
                    row_next   = '0;
                    state_next = S_ISSUE;
                end
                else
                begin
                    rx_st_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_RDTAKE;
            end
            S_RDTAKE:
            begin
                rec_next   = lane_rec[lane_sel_reg];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            fill_reg      <= '0;
            row_reg       <= '0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            side_reg  <= side_next;
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold the request fields, the working record and the result
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lane_sel_reg <= lane_sel_next;
        tgt_row_reg  <= tgt_row_next;
        rec_reg      <= rec_next;
        tx_st_reg    <= tx_st_next;
        rx_st_reg    <= rx_st_next;
        used_reg     <= used_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            rx_key_reg <= rx_mac;
            ptype_reg  <= packet_type;
            flen_reg   <= frame_length;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            o_tx_reg   <= tx_st_reg;
            o_rx_reg   <= rx_st_reg;
            o_used_reg <= used_reg;
            o_rec_reg  <= used_reg ? rec_reg : '0;
            o_fill_reg <= 7'(fill_reg);
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign tx_stored     = o_tx_reg;
    assign rx_stored     = o_rx_reg;
    assign entry_used    = o_used_reg;
    assign entry_mac     = o_rec_reg.mac;
    assign mgmt_tx_count = o_rec_reg.mgmt_tx;
    assign mgmt_rx_count = o_rec_reg.mgmt_rx;
    assign data_tx_count = o_rec_reg.data_tx;
    assign data_rx_count = o_rec_reg.data_rx;
    assign data_tx_bytes = o_rec_reg.tx_bytes;
    assign data_rx_bytes = o_rec_reg.rx_bytes;
    assign used_entries  = o_fill_reg;

endmodule

// ===== bench/tb_mac_address_stats_table.sv =====
// ----------------------------------------------------------------------------
// tb_mac_address_stats_table: self-checking bench for the address stats table
// Drives count, read and clear requests with random gaps and output stalls,
// predicts every result from a behavioral copy of the table and compares
// each result with its prediction.
// ----------------------------------------------------------------------------
module tb_mac_address_stats_table;

    localparam int DEPTH     = 64;
    localparam int MAX_CYCLE = 1000000;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [1:0] PTYPE_CTRL = 2'd1;
    localparam logic [1:0] PTYPE_MISC = 2'd3;

    typedef struct packed {
        logic        tx_stored;
        logic        rx_stored;
        logic        entry_used;
        logic [47:0] entry_mac;
        logic [31:0] mgmt_tx;
        logic [31:0] mgmt_rx;
        logic [31:0] data_tx;
        logic [31:0] data_rx;
        logic [63:0] tx_bytes;
        logic [63:0] rx_bytes;
        logic [6:0]  used;
    } stats_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] func = '0;
    logic [47:0] tx_mac = '0;
    logic [47:0] rx_mac = '0;
    logic [1:0] packet_type = '0;
    logic [11:0] frame_length = '0;
    logic [5:0] entry_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic tx_stored, rx_stored, entry_used;
    logic [47:0] entry_mac;
    logic [31:0] mgmt_tx_count, mgmt_rx_count, data_tx_count, data_rx_count;
    logic [63:0] data_tx_bytes, data_rx_bytes;
    logic [6:0] used_entries;

    // predicted table contents
    mast_pkg::entry_t shadow_table [DEPTH];
    int          shadow_fill;
    logic        shadow_record;
    stats_result_t pending_results [$];

    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    logic [47:0] addr_pool [8];

    mac_address_stats_table dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .tx_mac(tx_mac), .rx_mac(rx_mac),
        .packet_type(packet_type), .frame_length(frame_length),
        .entry_index(entry_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .tx_stored(tx_stored), .rx_stored(rx_stored), .entry_used(entry_used),
        .entry_mac(entry_mac),
        .mgmt_tx_count(mgmt_tx_count), .mgmt_rx_count(mgmt_rx_count),
        .data_tx_count(data_tx_count), .data_rx_count(data_rx_count),
        .data_tx_bytes(data_tx_bytes), .data_rx_bytes(data_rx_bytes),
        .used_entries(used_entries)
    );

    always #6 clk = ~clk;

    // Find addr in the table or append it; -1 when the table is full.
    function automatic int find_or_insert(logic [47:0] addr);
        for (int i = 0; i < shadow_fill; i++)
            if (shadow_table[i].mac == addr)
                return i;
        if (shadow_fill >= DEPTH)
            return -1;
        shadow_table[shadow_fill] = '0;
        shadow_table[shadow_fill].mac = addr;
        shadow_fill++;
        return shadow_fill - 1;
    endfunction

    // Apply one request to the table copy and return the result it yields.
    function automatic stats_result_t predict_stats(logic [1:0] f, logic [47:0] ta,
            logic [47:0] ra, logic [1:0] pt, logic [11:0] len, logic [5:0] idx);
        stats_result_t r;
        logic [63:0] payload;
        int t;
        int x;
        r = '0;
        payload = (len >= mast_pkg::CHECKSUM_BYTES) ?
                  64'(len - mast_pkg::CHECKSUM_BYTES) : 64'd0;
        if (f == mast_pkg::FUNC_COUNT) begin
            if (shadow_record) begin
                t = find_or_insert(ta);
                if (t >= 0) begin
                    r.tx_stored = 1'b1;
                    if (pt == mast_pkg::PTYPE_MGMT)
                        shadow_table[t].mgmt_tx++;
                    else if (pt == mast_pkg::PTYPE_DATA) begin
                        shadow_table[t].data_tx++;
                        shadow_table[t].tx_bytes += payload;
                    end
                end
                x = find_or_insert(ra);
                if (x >= 0) begin
                    r.rx_stored = 1'b1;
                    if (pt == mast_pkg::PTYPE_MGMT)
                        shadow_table[x].mgmt_rx++;
                    else if (pt == mast_pkg::PTYPE_DATA) begin
                        shadow_table[x].data_rx++;
                        shadow_table[x].rx_bytes += payload;
                    end
                end
            end
        end else if (f == mast_pkg::FUNC_READ) begin
            if (idx < shadow_fill) begin
                r.entry_used = 1'b1;
                r.entry_mac  = shadow_table[idx].mac;
                r.mgmt_tx    = shadow_table[idx].mgmt_tx;
                r.mgmt_rx    = shadow_table[idx].mgmt_rx;
                r.data_tx    = shadow_table[idx].data_tx;
                r.data_rx    = shadow_table[idx].data_rx;
                r.tx_bytes   = shadow_table[idx].tx_bytes;
                r.rx_bytes   = shadow_table[idx].rx_bytes;
            end
        end else if (f == mast_pkg::FUNC_CLEAR) begin
            shadow_fill = 0;
        end
        r.used = 7'(shadow_fill);
        return r;
    endfunction

    // Send one request: random idle first, then hold valid until accepted.
    task automatic send_request(logic [1:0] f, logic [47:0] ta, logic [47:0] ra,
            logic [1:0] pt, logic [11:0] len, logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid     <= 1'b1;
        func         <= f;
        tx_mac       <= ta;
        rx_mac       <= ra;
        packet_type  <= pt;
        frame_length <= len;
        entry_index  <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_stats(f, ta, ra, pt, len, idx));
        in_valid <= 1'b0;
        // the block leaves its idle state after taking a request
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        // a count request may still be scanning the table; allow margin
        repeat (100) @(posedge clk);
    endtask

    // Write record_enable; only called with the block idle.
    task automatic write_record(logic en);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_record = en;
    endtask

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Pick from a small address pool most of the time so entries get hits.
    function automatic logic [47:0] pick_addr();
        return ($urandom_range(3) != 0) ? addr_pool[$urandom_range(7)] : rand_addr();
    endfunction

    task automatic send_random_item();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            send_request(mast_pkg::FUNC_COUNT, pick_addr(), pick_addr(), 2'($urandom),
                         ($urandom_range(9) == 0) ? 12'($urandom_range(5)) : 12'($urandom),
                         6'($urandom));
        else if (sel < 94)
            send_request(mast_pkg::FUNC_READ, rand_addr(), rand_addr(), 2'($urandom),
                         12'($urandom),
                         6'($urandom_range(shadow_fill > 0 ? shadow_fill + 2 : 63)));
        else if (sel < 97)
            send_request(FUNC_NONE, rand_addr(), rand_addr(), 2'($urandom),
                         12'($urandom), 6'($urandom));
        else
            send_request(mast_pkg::FUNC_CLEAR, rand_addr(), rand_addr(), 2'($urandom),
                         12'($urandom), 6'($urandom));
    endtask

    // Directed: field extremes, every function and frame type, short frames,
    // same address both ways, disabled recording, unknown function.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // recording off
        send_request(mast_pkg::FUNC_COUNT, '1, '0, mast_pkg::PTYPE_DATA, 12'hFFF, '0);
        send_request(mast_pkg::FUNC_READ, '0, '0, mast_pkg::PTYPE_MGMT, '0, 6'd0);
        write_record(1'b1);
        send_request(mast_pkg::FUNC_COUNT, '1, '0, mast_pkg::PTYPE_DATA, 12'hFFF, '1);
        send_request(mast_pkg::FUNC_COUNT, '0, '1, mast_pkg::PTYPE_MGMT, '0, '0);
        send_request(mast_pkg::FUNC_COUNT, 48'h123, 48'h123, mast_pkg::PTYPE_DATA,
                     12'd3, '0);
        send_request(mast_pkg::FUNC_COUNT, 48'h123, 48'h123, mast_pkg::PTYPE_DATA,
                     12'd4, '0);
        send_request(mast_pkg::FUNC_COUNT, 48'h123, '1, mast_pkg::PTYPE_DATA, 12'd5, '0);
        send_request(mast_pkg::FUNC_COUNT, '1, 48'h123, PTYPE_CTRL, 12'd60, '0);
        send_request(mast_pkg::FUNC_COUNT, 48'h456, 48'h789, PTYPE_MISC, 12'd60, '0);
        for (int i = 0; i < 6; i++)
            send_request(mast_pkg::FUNC_READ, '0, '0, mast_pkg::PTYPE_MGMT, '0, 6'(i));
        send_request(mast_pkg::FUNC_READ, '1, '1, PTYPE_MISC, '1, '1);
        send_request(FUNC_NONE, '1, '1, PTYPE_MISC, '1, '1);
        write_record(1'b0);
        send_request(mast_pkg::FUNC_COUNT, 48'h55, 48'h66, mast_pkg::PTYPE_DATA,
                     12'd100, '0);
        // clears while off
        send_request(mast_pkg::FUNC_CLEAR, '0, '0, mast_pkg::PTYPE_MGMT, '0, '0);
        send_request(mast_pkg::FUNC_READ, '0, '0, mast_pkg::PTYPE_MGMT, '0, 6'd0);
        write_record(1'b1);
    endtask

    // Fill past capacity so inserts fail, then read the edge entries.
    task automatic test_table_full();
        send_request(mast_pkg::FUNC_CLEAR, '0, '0, mast_pkg::PTYPE_MGMT, '0, '0);
        for (int i = 0; i < 34; i++)
            send_request(mast_pkg::FUNC_COUNT, rand_addr(), rand_addr(),
                         mast_pkg::PTYPE_DATA, 12'($urandom), '0);
        send_request(mast_pkg::FUNC_COUNT, shadow_table[0].mac, rand_addr(),
                     mast_pkg::PTYPE_MGMT, '0, '0);
        send_request(mast_pkg::FUNC_READ, '0, '0, mast_pkg::PTYPE_MGMT, '0, 6'd0);
        send_request(mast_pkg::FUNC_READ, '0, '0, mast_pkg::PTYPE_MGMT, '0, 6'd63);
        send_request(mast_pkg::FUNC_CLEAR, '0, '0, mast_pkg::PTYPE_MGMT, '0, '0);
    endtask

    // Random traffic in several idle/stall phases with recording toggled.
    task automatic test_random_phases();
        int send_pct [4] = '{0, 52, 0, 33};
        int recv_pct [4] = '{0, 0, 52, 33};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int i = 0; i < 150; i++) begin
                send_random_item();
                // hold off until everything in flight has returned
                if (i == 75)
                    while (pending_results.size() != 0)
                        @(posedge clk);
            end
            write_record(p != 1);
        end
    endtask

    // Result checker: compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        stats_result_t got;
        stats_result_t want;
        if (out_valid && out_ready) begin
            got = '{tx_stored, rx_stored, entry_used, entry_mac, mgmt_tx_count,
                    mgmt_rx_count, data_tx_count, data_rx_count, data_tx_bytes,
                    data_rx_bytes, used_entries};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_fill = 0;
        shadow_record = 1'b0;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = rand_addr();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random_phases();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
